/* rtl/ldpm_pkg.sv */
// ----------------------------------------------------------------------------
// ldpm_pkg
// Shared widths, stage numbering, register codes and structs of the lens
// distortion point mapper.
// ----------------------------------------------------------------------------
package ldpm_pkg;

    localparam int COORD_W    = 32;
    localparam int PIX_W      = 32;
    localparam int COEF_W     = 32;
    localparam int FOCAL_W    = 24;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    // internal widths
    localparam int TAN_W = 42;
    localparam int F_W   = 56;

    // pipeline stages
    localparam int NUM_STAGES = 13;
    localparam int STG_IN     = 0;
    localparam int STG_SQ     = 1;
    localparam int STG_R2     = 2;
    localparam int STG_R4     = 3;
    localparam int STG_PART4  = 4;
    localparam int STG_R6     = 5;
    localparam int STG_PART6  = 6;
    localparam int STG_F      = 7;
    localparam int STG_XF     = 8;
    localparam int STG_XD     = 9;
    localparam int STG_PIX    = 10;
    localparam int STG_SUM    = 11;
    localparam int STG_OUT    = 12;

    localparam logic signed [49:0]      ONE_Q24 = 50'sd16777216;
    localparam logic signed [PIX_W-1:0] PIX_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [PIX_W-1:0] PIX_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X,
        REG_FOCAL_Y,
        REG_PRINCIPAL,
        REG_K1,
        REG_K2,
        REG_K3,
        REG_P1,
        REG_P2
    } cfg_index_t;

    typedef struct packed {
        logic [FOCAL_W-1:0] focal_x;
        logic [FOCAL_W-1:0] focal_y;
        logic [FOCAL_W-1:0] cx;
        logic [FOCAL_W-1:0] cy;
        logic [COEF_W-1:0]  k1;
        logic [COEF_W-1:0]  k2;
        logic [COEF_W-1:0]  k3;
        logic [COEF_W-1:0]  p1;
        logic [COEF_W-1:0]  p2;
    } cfg_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic                  in_ready;
        logic                  out_valid;
    } stage_ctrl_t;

    // handoff from the polynomial half to the projection half
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [F_W-1:0]     f;
        logic [TAN_W-1:0]   tx;
        logic [TAN_W-1:0]   ty;
        logic               last;
    } poly_t;

endpackage

/* rtl/ldpm_point_if.sv */
// ----------------------------------------------------------------------------
// ldpm_point_if
// Input channel: one normalized undistorted point per request.
// ----------------------------------------------------------------------------
interface ldpm_point_if;

    logic                                valid;
    logic                                ready;
    logic signed [ldpm_pkg::COORD_W-1:0] norm_x;
    logic signed [ldpm_pkg::COORD_W-1:0] norm_y;
    logic                                last_in;

    modport source (
        output valid,
        output norm_x,
        output norm_y,
        output last_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  norm_x,
        input  norm_y,
        input  last_in,
        output ready
    );

endinterface

/* rtl/ldpm_pixel_if.sv */
// ----------------------------------------------------------------------------
// ldpm_pixel_if
// Output channel: one distorted pixel coordinate per request.
// ----------------------------------------------------------------------------
interface ldpm_pixel_if;

    logic                              valid;
    logic                              ready;
    logic signed [ldpm_pkg::PIX_W-1:0] pixel_x;
    logic signed [ldpm_pkg::PIX_W-1:0] pixel_y;
    logic                              saturated;
    logic                              last_out;

    modport source (
        output valid,
        output pixel_x,
        output pixel_y,
        output saturated,
        output last_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  pixel_x,
        input  pixel_y,
        input  saturated,
        input  last_out,
        output ready
    );

endinterface

/* rtl/ldpm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ldpm_cfg_regs
// Write-only register file for focal lengths, principal point and the five
// distortion coefficients.
// ----------------------------------------------------------------------------
module ldpm_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [ldpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ldpm_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output ldpm_pkg::cfg_t                    cfg
);
    import ldpm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_FOCAL_X:   cfg_next.focal_x = cfg_wr_data[FOCAL_W-1:0];
                REG_FOCAL_Y:   cfg_next.focal_y = cfg_wr_data[FOCAL_W-1:0];
                REG_PRINCIPAL:
                begin
                    cfg_next.cx = cfg_wr_data[FOCAL_W-1:0];
                    cfg_next.cy = cfg_wr_data[2*FOCAL_W-1:FOCAL_W];
                end
                REG_K1:        cfg_next.k1 = cfg_wr_data[COEF_W-1:0];
                REG_K2:        cfg_next.k2 = cfg_wr_data[COEF_W-1:0];
                REG_K3:        cfg_next.k3 = cfg_wr_data[COEF_W-1:0];
                REG_P1:        cfg_next.p1 = cfg_wr_data[COEF_W-1:0];
                REG_P2:        cfg_next.p2 = cfg_wr_data[COEF_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/ldpm_stage_ctrl.sv */
// ----------------------------------------------------------------------------
// ldpm_stage_ctrl
// Valid bits of the pipeline stages and per-stage load enables; a stage
// loads whenever it is empty or everything downstream of it moves.
// ----------------------------------------------------------------------------
module ldpm_stage_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_ready,
    output ldpm_pkg::stage_ctrl_t ctrl
);
    import ldpm_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ready;
    logic [NUM_STAGES-1:0] shifted;

    // stage i may load when some stage at or after it is empty, or the sink takes
    always_comb
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            ready[i] = out_ready ||
                       ((valid_reg | NUM_STAGES'((1 << i) - 1)) != '1);
        end
    end

    assign shifted    = {valid_reg[NUM_STAGES-2:0], in_valid};
    assign valid_next = (ready & shifted) | (~ready & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.en        = ready;
    assign ctrl.in_ready  = ready[STG_IN];
    assign ctrl.out_valid = valid_reg[NUM_STAGES-1];

endmodule

/* rtl/ldpm_poly.sv */
// ----------------------------------------------------------------------------
// ldpm_poly
// Stages 0 to 7: squares, r2/r4/r6, radial factor f and the tangential
// terms. Wide products are split into two partial products at the shift
// point and summed in the following stage.
// ----------------------------------------------------------------------------
module ldpm_poly (
    input  logic                                clk,
    input  ldpm_pkg::stage_ctrl_t               ctrl,
    input  ldpm_pkg::cfg_t                      cfg,
    input  logic signed [ldpm_pkg::COORD_W-1:0] norm_x,
    input  logic signed [ldpm_pkg::COORD_W-1:0] norm_y,
    input  logic                                last_in,
    output ldpm_pkg::poly_t                     res
);
    import ldpm_pkg::*;

    logic signed [COEF_W-1:0] k1, k2, k3, p1, p2;

    // stage 0: input
    logic signed [31:0] x0_reg, y0_reg;
    logic               last0_reg;
    // stage 1: squares
    logic signed [63:0] m_xx, m_yy, m_xy;
    logic signed [31:0] xx1_reg, yy1_reg, xy1_reg, x1_reg, y1_reg;
    logic               last1_reg;
    // stage 2: r2 and tangential arguments
    logic signed [32:0] r2_next, ta_next;
    logic signed [33:0] tbx_next, tby_next;
    logic signed [32:0] r2_2_reg, ta2_reg;
    logic signed [33:0] tbx2_reg, tby2_reg;
    logic signed [31:0] x2_reg, y2_reg;
    logic               last2_reg;
    // stage 3: r4, k1*r2, tangential products
    logic signed [65:0] m_r4, m_p2bx, m_p1by;
    logic signed [64:0] m_k1r2, m_p1a, m_p2a;
    logic signed [39:0] r4_3_reg, k1r2_3_reg, p1a3_reg, p2a3_reg;
    logic signed [40:0] p2bx3_reg, p1by3_reg;
    logic signed [32:0] r2_3_reg;
    logic signed [31:0] x3_reg, y3_reg;
    logic               last3_reg;
    // stage 4: partial products on r4
    logic signed [15:0] r4h;
    logic signed [24:0] r4l;
    logic signed [48:0] m_r6h;
    logic signed [57:0] m_r6l;
    logic signed [47:0] m_k2h;
    logic signed [56:0] m_k2l;
    logic signed [TAN_W-1:0] tx_next, ty_next;
    logic signed [48:0] r6h4_reg;
    logic signed [57:0] r6l4_reg;
    logic signed [47:0] k2h4_reg;
    logic signed [56:0] k2l4_reg;
    logic signed [39:0] k1r2_4_reg;
    logic signed [TAN_W-1:0] tx4_reg, ty4_reg;
    logic signed [31:0] x4_reg, y4_reg;
    logic               last4_reg;
    // stage 5: r6, k2*r4
    logic signed [47:0] r6_next, k2r4_next;
    logic signed [47:0] r6_5_reg, k2r4_5_reg;
    logic signed [39:0] k1r2_5_reg;
    logic signed [TAN_W-1:0] tx5_reg, ty5_reg;
    logic signed [31:0] x5_reg, y5_reg;
    logic               last5_reg;
    // stage 6: partial products of k3*r6, partial radial sum
    logic signed [23:0] r6h;
    logic signed [24:0] r6l;
    logic signed [55:0] m_k3h;
    logic signed [56:0] m_k3l;
    logic signed [49:0] fa_next;
    logic signed [55:0] k3h6_reg;
    logic signed [56:0] k3l6_reg;
    logic signed [49:0] fa6_reg;
    logic signed [TAN_W-1:0] tx6_reg, ty6_reg;
    logic signed [31:0] x6_reg, y6_reg;
    logic               last6_reg;
    // stage 7: radial factor
    logic signed [F_W-1:0] f_next;
    logic signed [F_W-1:0] f7_reg;
    logic signed [TAN_W-1:0] tx7_reg, ty7_reg;
    logic signed [31:0] x7_reg, y7_reg;
    logic               last7_reg;

    assign k1 = $signed(cfg.k1);
    assign k2 = $signed(cfg.k2);
    assign k3 = $signed(cfg.k3);
    assign p1 = $signed(cfg.p1);
    assign p2 = $signed(cfg.p2);

    // ---- stage 0
    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_IN])
        begin
            x0_reg    <= norm_x;
            y0_reg    <= norm_y;
            last0_reg <= last_in;
        end
    end

    // ---- stage 1: upper words of the 64-bit products give the floor shift by 32
    assign m_xx = x0_reg * x0_reg;
    assign m_yy = y0_reg * y0_reg;
    assign m_xy = x0_reg * y0_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_SQ])
        begin
            xx1_reg   <= m_xx[63:32];
            yy1_reg   <= m_yy[63:32];
            xy1_reg   <= m_xy[63:32];
            x1_reg    <= x0_reg;
            y1_reg    <= y0_reg;
            last1_reg <= last0_reg;
        end
    end

    // ---- stage 2
    assign r2_next  = 33'(xx1_reg) + 33'(yy1_reg);
    assign ta_next  = 33'(xy1_reg) <<< 1;
    assign tbx_next = 34'(xx1_reg) + 34'(yy1_reg) + (34'(xx1_reg) <<< 1);
    assign tby_next = 34'(xx1_reg) + 34'(yy1_reg) + (34'(yy1_reg) <<< 1);

    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_R2])
        begin
            r2_2_reg  <= r2_next;
            ta2_reg   <= ta_next;
            tbx2_reg  <= tbx_next;
            tby2_reg  <= tby_next;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            last2_reg <= last1_reg;
        end
    end

    // ---- stage 3
    assign m_r4   = r2_2_reg * r2_2_reg;
    assign m_k1r2 = k1 * r2_2_reg;
    assign m_p1a  = p1 * ta2_reg;
    assign m_p2bx = p2 * tbx2_reg;
    assign m_p1by = p1 * tby2_reg;
    assign m_p2a  = p2 * ta2_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_R4])
        begin
            r4_3_reg   <= m_r4[63:24];
            k1r2_3_reg <= m_k1r2[63:24];
            p1a3_reg   <= m_p1a[63:24];
            p2bx3_reg  <= m_p2bx[64:24];
            p1by3_reg  <= m_p1by[64:24];
            p2a3_reg   <= m_p2a[63:24];
            r2_3_reg   <= r2_2_reg;
            x3_reg     <= x2_reg;
            y3_reg     <= y2_reg;
            last3_reg  <= last2_reg;
        end
    end

    // ---- stage 4: split r4 at bit 24 so each product stays narrow
    assign r4h     = $signed(r4_3_reg[39:24]);
    assign r4l     = $signed({1'b0, r4_3_reg[23:0]});
    assign m_r6h   = r4h * r2_3_reg;
    assign m_r6l   = r4l * r2_3_reg;
    assign m_k2h   = k2 * r4h;
    assign m_k2l   = k2 * r4l;
    assign tx_next = TAN_W'(p1a3_reg) + TAN_W'(p2bx3_reg);
    assign ty_next = TAN_W'(p1by3_reg) + TAN_W'(p2a3_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_PART4])
        begin
            r6h4_reg   <= m_r6h;
            r6l4_reg   <= m_r6l;
            k2h4_reg   <= m_k2h;
            k2l4_reg   <= m_k2l;
            k1r2_4_reg <= k1r2_3_reg;
            tx4_reg    <= tx_next;
            ty4_reg    <= ty_next;
            x4_reg     <= x3_reg;
            y4_reg     <= y3_reg;
            last4_reg  <= last3_reg;
        end
    end

    // ---- stage 5: floor(a*2^24 + b, 24) = a + floor(b, 24)
    assign r6_next   = 48'(r6h4_reg) + 48'($signed(r6l4_reg[57:24]));
    assign k2r4_next = k2h4_reg + 48'($signed(k2l4_reg[56:24]));

    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_R6])
        begin
            r6_5_reg   <= r6_next;
            k2r4_5_reg <= k2r4_next;
            k1r2_5_reg <= k1r2_4_reg;
            tx5_reg    <= tx4_reg;
            ty5_reg    <= ty4_reg;
            x5_reg     <= x4_reg;
            y5_reg     <= y4_reg;
            last5_reg  <= last4_reg;
        end
    end

    // ---- stage 6
    assign r6h     = $signed(r6_5_reg[47:24]);
    assign r6l     = $signed({1'b0, r6_5_reg[23:0]});
    assign m_k3h   = k3 * r6h;
    assign m_k3l   = k3 * r6l;
    assign fa_next = ONE_Q24 + 50'(k1r2_5_reg) + 50'(k2r4_5_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_PART6])
        begin
            k3h6_reg  <= m_k3h;
            k3l6_reg  <= m_k3l;
            fa6_reg   <= fa_next;
            tx6_reg   <= tx5_reg;
            ty6_reg   <= ty5_reg;
            x6_reg    <= x5_reg;
            y6_reg    <= y5_reg;
            last6_reg <= last5_reg;
        end
    end

    // ---- stage 7
    assign f_next = F_W'(fa6_reg) + k3h6_reg + F_W'($signed(k3l6_reg[56:24]));

    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_F])
        begin
            f7_reg    <= f_next;
            tx7_reg   <= tx6_reg;
            ty7_reg   <= ty6_reg;
            x7_reg    <= x6_reg;
            y7_reg    <= y6_reg;
            last7_reg <= last6_reg;
        end
    end

    assign res.x    = x7_reg;
    assign res.y    = y7_reg;
    assign res.f    = f7_reg;
    assign res.tx   = tx7_reg;
    assign res.ty   = ty7_reg;
    assign res.last = last7_reg;

endmodule

/* rtl/ldpm_project.sv */
// ----------------------------------------------------------------------------
// ldpm_project
// Stages 8 to 12: x*f and y*f, distorted coordinates, focal scaling,
// principal point offset and saturation to signed Q23.8.
// ----------------------------------------------------------------------------
module ldpm_project (
    input  logic                              clk,
    input  ldpm_pkg::stage_ctrl_t             ctrl,
    input  ldpm_pkg::cfg_t                    cfg,
    input  ldpm_pkg::poly_t                   poly,
    output logic signed [ldpm_pkg::PIX_W-1:0] pixel_x,
    output logic signed [ldpm_pkg::PIX_W-1:0] pixel_y,
    output logic                              saturated,
    output logic                              last_out
);
    import ldpm_pkg::*;

    // stage 8
    logic signed [31:0] px_in, py_in;
    logic signed [27:0] fh;
    logic signed [28:0] fl;
    logic signed [59:0] m_xh, m_yh;
    logic signed [60:0] m_xl, m_yl;
    logic signed [59:0] xh8_reg, yh8_reg;
    logic signed [60:0] xl8_reg, yl8_reg;
    logic signed [TAN_W-1:0] tx8_reg, ty8_reg;
    logic               last8_reg;
    // stage 9
    logic signed [59:0] xd_next, yd_next;
    logic signed [59:0] xd9_reg, yd9_reg;
    logic               last9_reg;
    // stage 10
    logic signed [24:0] fx25, fy25;
    logic signed [35:0] xdh, ydh;
    logic signed [24:0] xdl, ydl;
    logic signed [60:0] m_pxh, m_pyh;
    logic signed [49:0] m_pxl, m_pyl;
    logic signed [60:0] pxh10_reg, pyh10_reg;
    logic signed [49:0] pxl10_reg, pyl10_reg;
    logic               last10_reg;
    // stage 11
    logic signed [62:0] sx_next, sy_next;
    logic signed [62:0] sx11_reg, sy11_reg;
    logic               last11_reg;
    // stage 12
    logic               ovf_x, ovf_y;
    logic signed [PIX_W-1:0] clip_x, clip_y;
    logic signed [PIX_W-1:0] pixel_x_reg, pixel_y_reg;
    logic               sat_reg;
    logic               last12_reg;

    // ---- stage 8: split f at bit 28, the shift of x*f
    assign px_in = $signed(poly.x);
    assign py_in = $signed(poly.y);
    assign fh    = $signed(poly.f[F_W-1:28]);
    assign fl    = $signed({1'b0, poly.f[27:0]});
    assign m_xh  = px_in * fh;
    assign m_xl  = px_in * fl;
    assign m_yh  = py_in * fh;
    assign m_yl  = py_in * fl;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_XF])
        begin
            xh8_reg   <= m_xh;
            xl8_reg   <= m_xl;
            yh8_reg   <= m_yh;
            yl8_reg   <= m_yl;
            tx8_reg   <= $signed(poly.tx);
            ty8_reg   <= $signed(poly.ty);
            last8_reg <= poly.last;
        end
    end

    // ---- stage 9: distorted point, stays far inside the clip range
    assign xd_next = xh8_reg + 60'($signed(xl8_reg[60:28])) + 60'(tx8_reg);
    assign yd_next = yh8_reg + 60'($signed(yl8_reg[60:28])) + 60'(ty8_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_XD])
        begin
            xd9_reg   <= xd_next;
            yd9_reg   <= yd_next;
            last9_reg <= last8_reg;
        end
    end

    // ---- stage 10: split xd at bit 24 for the focal multiply
    assign fx25  = $signed({1'b0, cfg.focal_x});
    assign fy25  = $signed({1'b0, cfg.focal_y});
    assign xdh   = $signed(xd9_reg[59:24]);
    assign ydh   = $signed(yd9_reg[59:24]);
    assign xdl   = $signed({1'b0, xd9_reg[23:0]});
    assign ydl   = $signed({1'b0, yd9_reg[23:0]});
    assign m_pxh = xdh * fx25;
    assign m_pxl = xdl * fx25;
    assign m_pyh = ydh * fy25;
    assign m_pyl = ydl * fy25;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_PIX])
        begin
            pxh10_reg  <= m_pxh;
            pxl10_reg  <= m_pxl;
            pyh10_reg  <= m_pyh;
            pyl10_reg  <= m_pyl;
            last10_reg <= last9_reg;
        end
    end

    // ---- stage 11: scaled point plus principal point
    assign sx_next = 63'(pxh10_reg) + 63'($signed(pxl10_reg[49:24]))
                   + 63'($signed({1'b0, cfg.cx}));
    assign sy_next = 63'(pyh10_reg) + 63'($signed(pyl10_reg[49:24]))
                   + 63'($signed({1'b0, cfg.cy}));

    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_SUM])
        begin
            sx11_reg   <= sx_next;
            sy11_reg   <= sy_next;
            last11_reg <= last10_reg;
        end
    end

    // ---- stage 12: fits in 32 bits only if bits 62:31 are all equal
    assign ovf_x  = !((&sx11_reg[62:31]) || !(|sx11_reg[62:31]));
    assign ovf_y  = !((&sy11_reg[62:31]) || !(|sy11_reg[62:31]));
    assign clip_x = ovf_x ? (sx11_reg[62] ? PIX_MIN : PIX_MAX) : sx11_reg[31:0];
    assign clip_y = ovf_y ? (sy11_reg[62] ? PIX_MIN : PIX_MAX) : sy11_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.en[STG_OUT])
        begin
            pixel_x_reg <= clip_x;
            pixel_y_reg <= clip_y;
            sat_reg     <= ovf_x || ovf_y;
            last12_reg  <= last11_reg;
        end
    end

    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign saturated = sat_reg;
    assign last_out  = last12_reg;

endmodule

/* rtl/lens_distortion_point_map_unit.sv */
// ----------------------------------------------------------------------------
// lens_distortion_point_map_unit
// Throughput: one point per cycle through 13 register stages while the
// output is taken; the stage valid bits let a stall fill bubbles without
// losing or repeating a request.
// Reset clears all stage valid bits and every configuration register to zero.
// ----------------------------------------------------------------------------
module lens_distortion_point_map_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ldpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ldpm_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    ldpm_point_if.sink                      point,
    ldpm_pixel_if.source                    pixel
);
    import ldpm_pkg::*;

    cfg_t        cfg;
    stage_ctrl_t ctrl;
    poly_t       poly_res;

    ldpm_cfg_regs u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    ldpm_stage_ctrl u_stage_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .out_ready (pixel.ready),
        .ctrl      (ctrl)
    );

    ldpm_poly u_poly (
        .clk     (clk),
        .ctrl    (ctrl),
        .cfg     (cfg),
        .norm_x  (point.norm_x),
        .norm_y  (point.norm_y),
        .last_in (point.last_in),
        .res     (poly_res)
    );

    ldpm_project u_project (
        .clk       (clk),
        .ctrl      (ctrl),
        .cfg       (cfg),
        .poly      (poly_res),
        .pixel_x   (pixel.pixel_x),
        .pixel_y   (pixel.pixel_y),
        .saturated (pixel.saturated),
        .last_out  (pixel.last_out)
    );

    assign point.ready = ctrl.in_ready;
    assign pixel.valid = ctrl.out_valid;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lens distortion point mapper: streams normalized
// points under several coefficient and camera settings, predicts each pixel
// with exact wide fixed-point arithmetic and compares every returned request.
// ----------------------------------------------------------------------------
module tb_top;

    import ldpm_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last_flag;
    } point_req_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        logic                    sat;
        logic                    last_flag;
    } pixel_res_t;

    localparam wide_t CLIP_LIM  = 128'sh0FFF_FFFF_FFFF_FFFF;
    localparam wide_t UNITY_Q24 = 128'sd16777216;
    localparam wide_t PIX_HI    = 128'sd2147483647;
    localparam wide_t PIX_LO    = -128'sd2147483648;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] COORD_ONE = 32'sh1000_0000;

    localparam int STALL_LEN   = 120;
    localparam int DRAIN_WAIT  = 30;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    ldpm_point_if point ();
    ldpm_pixel_if pixel ();

    lens_distortion_point_map_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .point       (point.sink),
        .pixel       (pixel.source)
    );

    always #6 clk = ~clk;

    // shadow copy of the camera and lens registers
    logic [FOCAL_W-1:0] fx_m, fy_m, cx_m, cy_m;
    logic [COEF_W-1:0]  k1_m, k2_m, k3_m, p1_m, p2_m;

    point_req_t pending_points[$];
    pixel_res_t due_pixels[$];

    int  queued_cnt   = 0;
    int  accepted_cnt = 0;
    int  returned_cnt = 0;
    int  err_cnt      = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  stall_asks    = 0;
    bit  clip_flag;

    task automatic report(input string msg);
        err_cnt++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    function automatic wide_t clamp60(input wide_t v);
        if (v > CLIP_LIM)
        begin
            clip_flag = 1'b1;
            return CLIP_LIM;
        end
        if (v < -CLIP_LIM)
        begin
            clip_flag = 1'b1;
            return -CLIP_LIM;
        end
        return v;
    endfunction

    // exact product, floor shift, clip to the internal range
    function automatic wide_t mul_floor(input wide_t a, input wide_t b, input int sh);
        wide_t p;
        p = a * b;
        return clamp60(p >>> sh);
    endfunction

    function automatic pixel_res_t map_point(input point_req_t req);
        wide_t x, y, k1, k2, k3, p1, p2, fx, fy, cx, cy;
        wide_t xx, yy, xy, r2, r4, r6, f, xd, yd, px, py;
        pixel_res_t res;
        clip_flag = 1'b0;
        x  = wide_t'(req.x);
        y  = wide_t'(req.y);
        k1 = wide_t'($signed(k1_m));
        k2 = wide_t'($signed(k2_m));
        k3 = wide_t'($signed(k3_m));
        p1 = wide_t'($signed(p1_m));
        p2 = wide_t'($signed(p2_m));
        fx = wide_t'(fx_m);
        fy = wide_t'(fy_m);
        cx = wide_t'(cx_m);
        cy = wide_t'(cy_m);

        xx = mul_floor(x, x, 32);
        yy = mul_floor(y, y, 32);
        xy = mul_floor(x, y, 32);
        r2 = xx + yy;
        r4 = mul_floor(r2, r2, 24);
        r6 = mul_floor(r4, r2, 24);

        f  = clamp60(UNITY_Q24 + mul_floor(k1, r2, 24) + mul_floor(k2, r4, 24)
                     + mul_floor(k3, r6, 24));
        xd = clamp60(mul_floor(x, f, 28) + mul_floor(p1, 2 * xy, 24)
                     + mul_floor(p2, r2 + 2 * xx, 24));
        yd = clamp60(mul_floor(y, f, 28) + mul_floor(p1, r2 + 2 * yy, 24)
                     + mul_floor(p2, 2 * xy, 24));

        px = mul_floor(xd, fx, 24) + cx;
        py = mul_floor(yd, fy, 24) + cy;

        if (px > PIX_HI)
        begin
            px = PIX_HI;
            clip_flag = 1'b1;
        end
        else if (px < PIX_LO)
        begin
            px = PIX_LO;
            clip_flag = 1'b1;
        end
        if (py > PIX_HI)
        begin
            py = PIX_HI;
            clip_flag = 1'b1;
        end
        else if (py < PIX_LO)
        begin
            py = PIX_LO;
            clip_flag = 1'b1;
        end

        res.px        = px[PIX_W-1:0];
        res.py        = py[PIX_W-1:0];
        res.sat       = clip_flag;
        res.last_flag = req.last_flag;
        return res;
    endfunction

    // a gap in pct percent of the calls: mostly short ones, a few long ones
    function automatic int gap_len(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------------
    // point driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_points
        point_req_t req;
        int         send_gap;
        if (!rst_n)
        begin
            point.valid   <= 1'b0;
            point.norm_x  <= '0;
            point.norm_y  <= '0;
            point.last_in <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (point.valid && point.ready)
            begin
                req.x         = point.norm_x;
                req.y         = point.norm_y;
                req.last_flag = point.last_in;
                due_pixels = {due_pixels, map_point(req)};
                accepted_cnt++;
            end
            if (!point.valid || point.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    point.valid <= 1'b0;
                end
                else if (pending_points.size() > 0)
                begin
                    req = pending_points.pop_front();
                    point.norm_x  <= req.x;
                    point.norm_y  <= req.y;
                    point.last_in <= req.last_flag;
                    point.valid   <= 1'b1;
                    send_gap = gap_len(send_idle_pct);
                end
                else
                    point.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // pixel monitor and receiver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_pixels
        pixel_res_t want;
        int         recv_gap;
        int         stall_left;
        int         stall_taken;
        if (!rst_n)
        begin
            pixel.ready <= 1'b0;
            recv_gap    = 0;
            stall_left  = 0;
            stall_taken = 0;
        end
        else
        begin
            if (pixel.valid && pixel.ready)
            begin
                returned_cnt++;
                if (due_pixels.size() == 0)
                    report("pixel request with no point outstanding");
                else
                begin
                    want = due_pixels.pop_front();
                    if (pixel.pixel_x !== want.px)
                        report($sformatf("pixel_x got %0d want %0d", pixel.pixel_x, want.px));
                    if (pixel.pixel_y !== want.py)
                        report($sformatf("pixel_y got %0d want %0d", pixel.pixel_y, want.py));
                    if (pixel.saturated !== want.sat)
                        report($sformatf("saturated got %b want %b", pixel.saturated,
                                         want.sat));
                    if (pixel.last_out !== want.last_flag)
                        report($sformatf("last_out got %b want %b", pixel.last_out,
                                         want.last_flag));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pixel.ready <= 1'b0;
            end
            else if (stall_taken != stall_asks)
            begin
                stall_taken++;
                stall_left = STALL_LEN - 1;
                pixel.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                pixel.ready <= 1'b0;
            end
            else
            begin
                pixel.ready <= 1'b1;
                recv_gap = gap_len(recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic last_flag);
        point_req_t req;
        req.x         = x;
        req.y         = y;
        req.last_flag = last_flag;
        pending_points = {pending_points, req};
        queued_cnt++;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (!(accepted_cnt == queued_cnt && returned_cnt == accepted_cnt));
    endtask

    // bits above a register's width carry junk, the block must drop them
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] data;
        data[47:32] = 16'($urandom);
        data[31:0]  = $urandom;
        unique case (idx)
            REG_FOCAL_X:
            begin
                data[23:0] = value[23:0];
                fx_m = value[23:0];
            end
            REG_FOCAL_Y:
            begin
                data[23:0] = value[23:0];
                fy_m = value[23:0];
            end
            REG_PRINCIPAL:
            begin
                data = value;
                cx_m = value[23:0];
                cy_m = value[47:24];
            end
            REG_K1:
            begin
                data[31:0] = value[31:0];
                k1_m = value[31:0];
            end
            REG_K2:
            begin
                data[31:0] = value[31:0];
                k2_m = value[31:0];
            end
            REG_K3:
            begin
                data[31:0] = value[31:0];
                k3_m = value[31:0];
            end
            REG_P1:
            begin
                data[31:0] = value[31:0];
                p1_m = value[31:0];
            end
            REG_P2:
            begin
                data[31:0] = value[31:0];
                p2_m = value[31:0];
            end
        endcase
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
    endtask

    task automatic load_config(input logic [23:0] fx, input logic [23:0] fy,
                               input logic [23:0] cx, input logic [23:0] cy,
                               input logic [31:0] k1, input logic [31:0] k2,
                               input logic [31:0] k3, input logic [31:0] p1,
                               input logic [31:0] p2);
        write_reg(REG_FOCAL_X, CFG_DATA_W'(fx));
        write_reg(REG_FOCAL_Y, CFG_DATA_W'(fy));
        write_reg(REG_PRINCIPAL, {cy, cx});
        write_reg(REG_K1, CFG_DATA_W'(k1));
        write_reg(REG_K2, CFG_DATA_W'(k2));
        write_reg(REG_K3, CFG_DATA_W'(k3));
        write_reg(REG_P1, CFG_DATA_W'(p1));
        write_reg(REG_P2, CFG_DATA_W'(p2));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_config(input bit wild);
        if (wild)
            load_config(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                        $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            load_config(24'($urandom_range(100 * 256, 2000 * 256)),
                        24'($urandom_range(100 * 256, 2000 * 256)),
                        24'($urandom_range(0, 2000 * 256)),
                        24'($urandom_range(0, 2000 * 256)),
                        32'($urandom_range(0, 1 << 24)) - 32'd8388608,
                        32'($urandom_range(0, 1 << 22)) - 32'd2097152,
                        32'($urandom_range(0, 1 << 20)) - 32'd524288,
                        32'($urandom_range(0, 335544)) - 32'd167772,
                        32'($urandom_range(0, 335544)) - 32'd167772);
    endtask

    // mostly points within about 1.5 of the axis, then full range and corners
    function automatic logic [COORD_W-1:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14)
            return 32'($urandom_range(0, 805306368)) - 32'd402653184;
        if (sel < 18)
            return $urandom;
        unique case ($urandom_range(0, 4))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return 32'sd1;
            3:       return -32'sd1;
            default: return '0;
        endcase
    endfunction

    initial
    begin : run_stimulus
        int ph;
        int n;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= '0;
        cfg_wr_data <= '0;
        fx_m = '0; fy_m = '0; cx_m = '0; cy_m = '0;
        k1_m = '0; k2_m = '0; k3_m = '0; p1_m = '0; p2_m = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at their reset values
        send_idle_pct = 20;
        recv_idle_pct = 20;
        push_point('0, '0, 1'b0);
        push_point(COORD_MAX, COORD_MIN, 1'b0);
        push_point(COORD_ONE, -COORD_ONE, 1'b1);
        wait_drained();

        // typical camera, mild barrel distortion
        load_config(24'd500 << 8, 24'd480 << 8, 24'd320 << 8, 24'd240 << 8,
                    -32'sd3355443, 32'sd838861, 32'sd16777, 32'sd16777, -32'sd8389);
        push_point('0, '0, 1'b0);
        push_point(COORD_ONE, '0, 1'b0);
        push_point('0, COORD_ONE, 1'b0);
        push_point(-COORD_ONE, -COORD_ONE, 1'b0);
        push_point(COORD_MAX, COORD_MAX, 1'b0);
        push_point(COORD_MIN, COORD_MIN, 1'b0);
        push_point(COORD_MIN, COORD_MAX, 1'b0);
        push_point(32'sd1, -32'sd1, 1'b0);
        push_point(-32'sd1, 32'sd1, 1'b0);
        push_point(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        wait_drained();

        // every register at its top value, outputs clip
        load_config('1, '1, '1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_point('0, '0, 1'b0);
        push_point(COORD_MAX, COORD_MAX, 1'b0);
        push_point(COORD_MIN, COORD_MIN, 1'b0);
        push_point(COORD_ONE, -COORD_ONE, 1'b1);
        wait_drained();

        // most negative coefficients
        load_config('1, '1, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000);
        push_point(COORD_MAX, COORD_MIN, 1'b0);
        push_point(COORD_MIN, COORD_MAX, 1'b0);
        push_point(32'sh0800_0000, 32'sh0800_0000, 1'b1);
        wait_drained();

        // zero focal length leaves only the principal point
        load_config('0, '0, 24'($urandom), 24'($urandom), $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        push_point(COORD_MAX, COORD_MAX, 1'b0);
        push_point(COORD_MIN, COORD_ONE, 1'b0);
        push_point(32'h1234_5678, 32'h8765_4321, 1'b1);
        wait_drained();

        for (ph = 0; ph < 10; ph++)
        begin
            random_config(ph % 3 == 2);
            unique case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 30;
                end
                2:
                begin
                    send_idle_pct = 10;
                    recv_idle_pct = 50;
                end
                default:
                begin
                    send_idle_pct = 60;
                    recv_idle_pct = 10;
                end
            endcase
            for (n = 0; n < 105; n++)
                push_point(pick_coord(), pick_coord(), $urandom_range(0, 7) == 0);

            // receiver holds off while the sender keeps the input busy
            if (ph == 5)
            begin
                wait_drained();
                send_idle_pct = 0;
                stall_asks++;
                for (n = 0; n < 60; n++)
                    push_point(pick_coord(), pick_coord(), $urandom_range(0, 7) == 0);
            end
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (due_pixels.size() != 0)
            report($sformatf("%0d pixel requests never arrived", due_pixels.size()));
        if (err_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
